// File: rtl/tsc_pkg.sv
// Shared types, constants and helper functions of the Taylor sine/cosine block.
package tsc_pkg;

	localparam int MAX_TERMS = 32;
	localparam int FRAC_BITS = 28;

	localparam int ANGLE_W = 32;
	localparam int RES_W   = 31;
	localparam int N_W     = 7;
	localparam int THR_W   = 29;

	// term magnitude is capped at 2^56
	localparam int MAG_W   = 57;
	// x*x >> FRAC_BITS for |x| <= 2^31
	localparam int X2_W    = 2 * ANGLE_W - 1 - FRAC_BITS;

	// multiplier: X2_W bits times one CHUNK_W slice of a MB_W operand per cycle
	localparam int CHUNK_W = 15;
	localparam int CHUNKS  = 4;
	localparam int MB_W    = CHUNK_W * CHUNKS;
	localparam int ACC_W   = X2_W + MB_W;

	// divider: DIV_DIG quotient bits per cycle over a DIVN_W dividend
	localparam int DIV_DIG   = 4;
	localparam int DIVN_W    = 64;
	localparam int DIV_STEPS = DIVN_W / DIV_DIG;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int D_W       = $clog2((2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1) + 1);

	localparam int SUM_W = 64;

	localparam logic [MAG_W-1:0]         TERM_CAP = MAG_W'(1) << (MAG_W - 1);
	localparam logic [MAG_W-1:0]         ONE_FX   = MAG_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0]  OUT_MAX  = 64'sd536870912;

	localparam logic [THR_W-1:0] SINE_THR_RST   = 29'd26844;
	localparam logic [THR_W-1:0] COSINE_THR_RST = 29'd27;

	// configuration register indexes
	localparam logic REG_SINE_THR   = 1'b0;
	localparam logic REG_COSINE_THR = 1'b1;

	// function select codes
	localparam logic CMD_SINE   = 1'b0;
	localparam logic CMD_COSINE = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] angle;
	} arg_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic [N_W-1:0]          terms_used;
		logic                    limit_hit;
	} res_t;

	// divisor of term n: (2n-2)(2n-1) for sine, (2n-2)(2n-3) for cosine
	function automatic logic [D_W-1:0] term_divisor(input logic [N_W-1:0] n, input logic cos_sel);
		logic [N_W:0]     two_n;
		logic [N_W:0]     a;
		logic [N_W:0]     b;
		logic [2*N_W+1:0] p;
		two_n = {n, 1'b0};
		a = two_n - (N_W+1)'(2);
		b = cos_sel ? two_n - (N_W+1)'(3) : two_n - (N_W+1)'(1);
		p = a * b;
		return p[D_W-1:0];
	endfunction

	// stop rule: cosine stops at or below its threshold, sine strictly below
	function automatic logic term_passes(input logic cos_sel, input logic [MAG_W-1:0] mag,
			input logic [THR_W-1:0] sthr, input logic [THR_W-1:0] cthr);
		logic r;
		if (cos_sel) r = (mag <= MAG_W'(cthr));
		else r = (mag < MAG_W'(sthr));
		return r;
	endfunction

endpackage

// File: rtl/taylor_sine_cosine.sv
// Top level of the Taylor-series sine/cosine block: sequencer, shared multiplier and divider.
//
// Usage:
//   arg channel (arg_valid/arg_ready/arg) carries one item: cmd (0 sine, 1 cosine) and a
//   signed angle with 28 fraction bits. res channel (res_valid/res_ready/res) returns the
//   saturated sum, the number of terms summed and a flag set when the term limit ends the
//   series. Stop thresholds are written over the APB port: sine at 0x0, cosine at 0x4.
// Timing:
//   One item is worked at a time; arg_ready is high only while the sequencer is idle.
//   The square of the angle is formed on the multiplier, followed by a setup state; every
//   further term takes a multiply (one 15-bit slice per cycle), a divide (4 quotient
//   bits per cycle) and an accumulate step. The result is registered once the sequencer
//   is in S_FIN and the output register is free; the next item is then taken in the idle state.
//   At most 32 terms are summed.
// Reset and stalls:
//   arst_n clears the sequencer and the output valid flag and loads the reset thresholds.
//   A finished result waits in the output register; the sequencer may take and work the
//   next item meanwhile and holds its own result until the register is free.
module taylor_sine_cosine
	import tsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        arg_valid,
	output logic        arg_ready,
	input  arg_t        arg,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SQUARE = 7'b0000010,
		S_INIT   = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_ACC    = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [THR_W-1:0] sthr_q;
	logic [THR_W-1:0] cthr_q;

	logic              cos_q;
	logic              neg_x_q;
	logic [ANGLE_W-1:0] m_q;
	logic [X2_W-1:0]   x2_q;
	logic              neg_t_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [N_W-1:0]    n_q;
	logic              done_q;
	logic [D_W-1:0]    d_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [X2_W-1:0]   mul_a_q;
	logic [MB_W-1:0]   mul_b_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DIVN_W-1:0] div_q;
	logic [D_W-1:0]    rem_q;

	logic              res_valid_q;
	res_t              res_q;

	// APB register access
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COSINE_THR) ? 32'(cthr_q) : 32'(sthr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sthr_q <= SINE_THR_RST;
			cthr_q <= COSINE_THR_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SINE_THR) sthr_q <= pwdata[THR_W-1:0];
			else cthr_q <= pwdata[THR_W-1:0];
		end
	end

	// input decode: magnitude of the angle
	logic [ANGLE_W-1:0] raw;
	logic [ANGLE_W-1:0] m_in;
	assign raw  = arg.angle;
	assign m_in = raw[ANGLE_W-1] ? (~raw + ANGLE_W'(1)) : raw;

	// shared multiplier: one slice of operand B per cycle, MSB slice first
	logic [X2_W+CHUNK_W-1:0] prod;
	logic [ACC_W-1:0]        acc_next;
	assign prod     = mul_a_q * mul_b_q[MB_W-1 -: CHUNK_W];
	assign acc_next = (acc_q << CHUNK_W) + ACC_W'(prod);

	// shared divider: DIV_DIG restoring steps per cycle, dividend taken from the
	// accumulator on the first cycle
	logic [DIVN_W-1:0]  div_src;
	logic [D_W-1:0]     rem_next;
	logic [DIV_DIG-1:0] qdig;
	logic [D_W:0]       trial;
	assign div_src = (cnt_q == '0) ? acc_q[FRAC_BITS +: DIVN_W] : div_q;

	always_comb begin
		rem_next = rem_q;
		qdig     = '0;
		trial    = '0;
		for (int i = 0; i < DIV_DIG; i++) begin
			trial = {rem_next, div_src[DIVN_W-1-i]};
			if (trial >= {1'b0, d_q}) begin
				trial = trial - {1'b0, d_q};
				qdig[DIV_DIG-1-i] = 1'b1;
			end
			rem_next = trial[D_W-1:0];
		end
	end

	// first term and new term magnitude
	logic [MAG_W-1:0] mag_first;
	logic             neg_first;
	logic [MAG_W-1:0] mag_new;
	logic             first_pass;
	logic             new_pass;
	assign mag_first  = (cos_q == CMD_COSINE) ? ONE_FX : MAG_W'(m_q);
	assign neg_first  = (cos_q == CMD_COSINE) ? 1'b0 : neg_x_q;
	assign mag_new    = (div_q > DIVN_W'(TERM_CAP)) ? TERM_CAP : div_q[MAG_W-1:0];
	assign first_pass = term_passes(cos_q, mag_first, sthr_q, cthr_q);
	assign new_pass   = term_passes(cos_q, mag_new, sthr_q, cthr_q);

	// final saturation
	logic signed [SUM_W-1:0] sum_sat;
	assign sum_sat = (sum_q > OUT_MAX) ? OUT_MAX : ((sum_q < -OUT_MAX) ? -OUT_MAX : sum_q);

	logic fin_load;
	assign fin_load  = (state_q == S_FIN) && (!res_valid_q || res_ready);
	assign arg_ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (arg_valid) begin
						state_q <= S_SQUARE;
						cnt_q   <= '0;
					end
				end
				S_SQUARE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CHUNKS - 1)) state_q <= S_INIT;
				end
				S_INIT: begin
					cnt_q   <= '0;
					state_q <= first_pass ? S_FIN : S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(CHUNKS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_ACC;
				end
				S_ACC: begin
					cnt_q <= '0;
					// stop on a small term or once the last allowed term is summed
					if (new_pass || n_q == N_W'(MAX_TERMS - 1)) state_q <= S_FIN;
					else state_q <= S_MUL;
				end
				S_FIN: begin
					if (fin_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (arg_valid) begin
					cos_q   <= arg.cmd;
					neg_x_q <= raw[ANGLE_W-1];
					m_q     <= m_in;
					mul_a_q <= X2_W'(m_in);
					mul_b_q <= MB_W'(m_in);
					acc_q   <= '0;
				end
			end
			S_SQUARE, S_MUL: begin
				acc_q   <= acc_next;
				mul_b_q <= mul_b_q << CHUNK_W;
				rem_q   <= '0;
			end
			S_INIT: begin
				x2_q    <= acc_q[FRAC_BITS +: X2_W];
				neg_t_q <= neg_first;
				sum_q   <= neg_first ? -$signed(SUM_W'(mag_first)) : $signed(SUM_W'(mag_first));
				n_q     <= N_W'(1);
				done_q  <= first_pass;
				d_q     <= term_divisor(N_W'(2), cos_q);
				mul_a_q <= acc_q[FRAC_BITS +: X2_W];
				mul_b_q <= MB_W'(mag_first);
				acc_q   <= '0;
			end
			S_DIV: begin
				div_q <= {div_src[DIVN_W-DIV_DIG-1:0], qdig};
				rem_q <= rem_next;
			end
			S_ACC: begin
				neg_t_q <= !neg_t_q;
				sum_q   <= (!neg_t_q) ? sum_q - $signed(SUM_W'(mag_new))
						: sum_q + $signed(SUM_W'(mag_new));
				done_q  <= new_pass;
				n_q     <= n_q + N_W'(1);
				d_q     <= term_divisor(n_q + N_W'(2), cos_q);
				mul_a_q <= x2_q;
				mul_b_q <= MB_W'(mag_new);
				acc_q   <= '0;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			res_q.result_value <= sum_sat[RES_W-1:0];
			res_q.terms_used   <= n_q;
			res_q.limit_hit    <= !done_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_terms_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.terms_used >= N_W'(1)) && (res.terms_used <= N_W'(MAX_TERMS)))
		else $error("terms_used out of range");
	a_limit_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.limit_hit |-> res.terms_used == N_W'(MAX_TERMS))
		else $error("limit flag set before the term limit");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && arg_ready |=> state_q == S_SQUARE)
		else $error("accepted item did not start the square");
	a_rem_below_d: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < d_q)
		else $error("divider remainder not below divisor");
`endif

endmodule
